### rtl/glap_pkg.sv
package glap_pkg;

  localparam int unsigned GRID_CELLS = 4096;
  localparam int unsigned ADDR_W     = $clog2(GRID_CELLS);

  localparam int unsigned IDX_W   = 12;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned NB_W    = 16;
  localparam int unsigned DIST_W  = 16;
  localparam int unsigned LAP_W   = 48;
  localparam int unsigned IN_W    = 144;
  localparam int unsigned CFG_A_W = 3;

  // divider and accumulator widths
  localparam int unsigned NUM_W = 51;           // numerator magnitude
  localparam int unsigned DEN_W = DIST_W + 1;   // d1 + d2
  localparam int unsigned F_W   = 42;           // first differences
  localparam int unsigned AX_W  = 52;           // quotient, signed
  localparam int unsigned SUM_W = 54;
  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  typedef enum logic [CFG_A_W-1:0] {
    REG_DIST_PX = 3'd0,
    REG_DIST_MX = 3'd1,
    REG_DIST_PY = 3'd2,
    REG_DIST_MY = 3'd3,
    REG_DIST_PZ = 3'd4,
    REG_DIST_MZ = 3'd5
  } cfg_reg_t;

  typedef enum logic {
    MODE_WRITE   = 1'b0,
    MODE_COMPUTE = 1'b1
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } state_t;

  // true when a signed neighbour index lies outside the grid
  function automatic logic nb_outside(input logic signed [NB_W-1:0] nb);
    nb_outside = nb[NB_W-1] || (32'(unsigned'(nb)) >= GRID_CELLS);
  endfunction

endpackage

### rtl/grid_laplacian_nonuniform.sv
// Seven-point Laplacian with non-uniform spacing over a stored grid.
// Input stream: tuser = mode (0 writes cell_value at the centre index, 1 computes
// the Laplacian at the centre index from its six neighbour indices). A write gives
// no result; a compute gives exactly one 48-bit saturated result on the out_
// stream. Neighbour indices outside the grid take the centre value.
// Distances come from cfg writes (index 0..5: px, mx, py, my, pz, mz, Q8.8).
// A write transaction leaves the control in idle, so writes can follow back to back.
// A compute transaction runs from acceptance to result through a read phase,
// in which seven reads pass through the single read port of the grid memory
// (registered read data), nine divisions on one shared restoring divider
// (a load state, then steps at one quotient bit a cycle), and a final state
// that registers the result. No new item is taken until then; the next item
// is taken in the cycle the result appears. Writes are taken while a finished
// result still waits in the output register; a compute then waits only in
// its final state until the register frees.
// Reset clears the control state and sets all distances to 1.0 um; grid
// contents are undefined until written. When the receiver stalls, the result
// holds in out_tdata and no further compute completes.
module grid_laplacian_nonuniform
  import glap_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // centre_idx, cell_value, nb_plus_x, nb_minus_x, nb_plus_y, nb_minus_y,
  // nb_plus_z, nb_minus_z, zero fill
  input  logic [IN_W-1:0]     in_tdata,
  input  logic                in_tuser,   // mode
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [LAP_W-1:0]    out_tdata,  // laplacian
  input  logic                cfg_we,
  input  logic [CFG_A_W-1:0]  cfg_idx,
  input  logic [DIST_W-1:0]   cfg_wdata
);

  logic [VAL_W-1:0] mem [GRID_CELLS];
  logic [VAL_W-1:0] mem_q;
  logic             mem_we;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;

  state_t state_r, state_nxt;
  logic [DIST_W-1:0] dist_r [6];

  logic [IDX_W-1:0]  idx_r;
  logic signed [NB_W-1:0] nb_r [7];
  logic [6:0]        oob_r;
  logic signed [VAL_W-1:0] v_r [7];
  logic [2:0]        rd_step_r;
  logic [1:0]        axis_r, op_r;
  logic signed [F_W-1:0] f1_r, f2_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [NUM_W-1:0]  q_r;
  logic [DEN_W-1:0]  rem_r, den_r;
  logic              neg_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              out_valid_r;
  logic [LAP_W-1:0]  out_data_r;

  logic in_acc, is_comp, out_free;
  logic [IDX_W-1:0] in_idx;
  logic signed [NB_W-1:0] in_nb [7];

  assign in_acc   = in_tvalid && in_tready;
  assign in_idx   = in_tdata[IDX_W-1:0];
  assign is_comp  = (in_tuser == MODE_COMPUTE);
  assign out_free = !out_valid_r || out_tready;

  // slot 0 centre, then minus/plus per axis
  always_comb begin
    in_nb[0] = '0;
    in_nb[1] = in_tdata[75:60];
    in_nb[2] = in_tdata[59:44];
    in_nb[3] = in_tdata[107:92];
    in_nb[4] = in_tdata[91:76];
    in_nb[5] = in_tdata[139:124];
    in_nb[6] = in_tdata[123:108];
  end

  // ---------------- memory ----------------
  assign mem_we    = in_acc && !is_comp && (32'(in_idx) < GRID_CELLS);
  assign mem_waddr = ADDR_W'(in_idx);
  // last read step only collects the data of step six
  always_comb begin
    if (rd_step_r == 3'd0 || rd_step_r == 3'd7) begin
      mem_raddr = ADDR_W'(idx_r);
    end else begin
      mem_raddr = ADDR_W'(unsigned'(nb_r[rd_step_r]));
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= in_tdata[IDX_W +: VAL_W];
    end
    mem_q <= mem[mem_raddr];
  end

  // ---------------- axis operands ----------------
  logic signed [VAL_W-1:0] vc, vp, vn;
  logic [DIST_W-1:0] d1_raw, d2_raw;
  logic [DEN_W-1:0]  d1, d2;
  logic [2:0] sp, sn;

  always_comb begin
    sp = {axis_r, 1'b0} + 3'd1;
    sn = {axis_r, 1'b0} + 3'd2;
    vc = v_r[0];
    vp = oob_r[sp] ? v_r[0] : v_r[sp];
    vn = oob_r[sn] ? v_r[0] : v_r[sn];
    d1_raw = dist_r[sp];
    d2_raw = dist_r[{axis_r, 1'b0}];
    d1 = (d1_raw == '0) ? DEN_W'(1) : DEN_W'(d1_raw);
    d2 = (d2_raw == '0) ? DEN_W'(1) : DEN_W'(d2_raw);
  end

  logic signed [VAL_W:0]   diff;
  logic signed [F_W:0]     fdiff;
  logic signed [AX_W-1:0]  num;
  logic [DEN_W-1:0]        den;
  logic [AX_W-1:0]         mag;

  always_comb begin
    diff  = '0;
    fdiff = '0;
    case (op_r)
      2'd0: begin
        diff = (VAL_W+1)'(vc) - (VAL_W+1)'(vp);
        num  = AX_W'(diff) <<< 8;
        den  = d1;
      end
      2'd1: begin
        diff = (VAL_W+1)'(vn) - (VAL_W+1)'(vc);
        num  = AX_W'(diff) <<< 8;
        den  = d2;
      end
      2'd2: begin
        fdiff = (F_W+1)'(f2_r) - (F_W+1)'(f1_r);
        num   = AX_W'(fdiff) <<< 9;
        den   = d1 + d2;
      end
      default: begin
        num = '0;
        den = DEN_W'(1);
      end
    endcase
    mag = num[AX_W-1] ? AX_W'(-num) : AX_W'(num);
  end

  // one restoring step
  logic [DEN_W:0]  rs;
  logic            qbit;
  logic [DEN_W:0]  rs_sub;
  logic [NUM_W-1:0] q_step;
  logic signed [AX_W-1:0] quot;

  always_comb begin
    rs     = {rem_r, q_r[NUM_W-1]};
    rs_sub = rs - {1'b0, den_r};
    qbit   = (rs >= {1'b0, den_r});
    q_step = {q_r[NUM_W-2:0], qbit};
    quot   = neg_r ? -AX_W'(q_r) : AX_W'(q_r);
  end

  // ---------------- control ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && is_comp) begin
          state_nxt = (32'(in_idx) < GRID_CELLS) ? ST_READ : ST_DONE;
        end
      end
      ST_READ: begin
        if (rd_step_r == 3'd7) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: state_nxt = ST_DIV;
      ST_DIV: begin
        if (cnt_r == CNT_W'(NUM_W)) begin
          state_nxt = (op_r == 2'd2 && axis_r == 2'd2) ? ST_DONE : ST_LOAD;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = (state_r == ST_IDLE);
    out_tvalid = out_valid_r;
    out_tdata  = out_data_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      dist_r[0] <= DIST_W'(256);
      dist_r[1] <= DIST_W'(256);
      dist_r[2] <= DIST_W'(256);
      dist_r[3] <= DIST_W'(256);
      dist_r[4] <= DIST_W'(256);
      dist_r[5] <= DIST_W'(256);
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          REG_DIST_PX: dist_r[0] <= cfg_wdata;
          REG_DIST_MX: dist_r[1] <= cfg_wdata;
          REG_DIST_PY: dist_r[2] <= cfg_wdata;
          REG_DIST_MY: dist_r[3] <= cfg_wdata;
          REG_DIST_PZ: dist_r[4] <= cfg_wdata;
          REG_DIST_MZ: dist_r[5] <= cfg_wdata;
          default: ;
        endcase
      end
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_acc && is_comp) begin
          idx_r     <= in_idx;
          rd_step_r <= 3'd0;
          axis_r    <= 2'd0;
          op_r      <= 2'd0;
          sum_r     <= '0;
          for (int k = 0; k < 7; k++) begin
            nb_r[k]  <= in_nb[k];
            oob_r[k] <= (k != 0) && nb_outside(in_nb[k]);
          end
        end
      end
      ST_READ: begin
        rd_step_r <= rd_step_r + 3'd1;
        if (rd_step_r != 3'd0) begin
          v_r[rd_step_r - 3'd1] <= mem_q;
        end
      end
      ST_LOAD: begin
        q_r   <= mag[NUM_W-1:0];
        neg_r <= num[AX_W-1];
        den_r <= den;
        rem_r <= '0;
        cnt_r <= '0;
      end
      ST_DIV: begin
        if (cnt_r == CNT_W'(NUM_W)) begin
          case (op_r)
            2'd0: begin
              f1_r <= F_W'(quot);
              op_r <= 2'd1;
            end
            2'd1: begin
              f2_r <= F_W'(quot);
              op_r <= 2'd2;
            end
            default: begin
              sum_r  <= sum_r + SUM_W'(quot);
              op_r   <= 2'd0;
              axis_r <= axis_r + 2'd1;
            end
          endcase
        end else begin
          q_r   <= q_step;
          rem_r <= qbit ? rs_sub[DEN_W-1:0] : rs[DEN_W-1:0];
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          if (sum_r[SUM_W-1:LAP_W-1] == '0 || sum_r[SUM_W-1:LAP_W-1] == '1) begin
            out_data_r <= sum_r[LAP_W-1:0];
          end else if (sum_r[SUM_W-1]) begin
            out_data_r <= {1'b1, {(LAP_W-1){1'b0}}};
          end else begin
            out_data_r <= {1'b0, {(LAP_W-1){1'b1}}};
          end
        end
      end
      default: ;
    endcase
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import glap_pkg::*;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata;
  logic              in_tuser;
  logic              out_tvalid;
  logic              out_tready;
  logic [LAP_W-1:0]  out_tdata;
  logic              cfg_we;
  logic [CFG_A_W-1:0] cfg_idx;
  logic [DIST_W-1:0] cfg_wdata;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 600;

  typedef struct packed {
    logic [3:0]             fill;
    logic signed [NB_W-1:0] nmz;
    logic signed [NB_W-1:0] npz;
    logic signed [NB_W-1:0] nmy;
    logic signed [NB_W-1:0] npy;
    logic signed [NB_W-1:0] nmx;
    logic signed [NB_W-1:0] npx;
    logic signed [VAL_W-1:0] val;
    logic [IDX_W-1:0]       idx;
  } cell_op_t;

  // Laplacian predictor: owns a mirror of grid and distance registers
  class laplacian_scoreboard;
    logic signed [VAL_W-1:0] cells [GRID_CELLS];
    logic [DIST_W-1:0]       spacing [6];
    logic signed [LAP_W-1:0] pending [$];
    int errors;
    int checked;

    function void clear();
      foreach (spacing[i]) spacing[i] = 16'd256;
      errors = 0;
      checked = 0;
    endfunction

    function longint pick(logic signed [NB_W-1:0] nb, longint centre);
      if (nb < 0 || nb >= GRID_CELLS) return centre;
      return longint'(cells[nb]);
    endfunction

    function longint axis(logic [DIST_W-1:0] dp, logic [DIST_W-1:0] dn,
                          longint vp, longint vc, longint vn);
      longint d1, d2, f1, f2;
      d1 = (dp == 0) ? 1 : longint'(dp);
      d2 = (dn == 0) ? 1 : longint'(dn);
      f1 = ((vc - vp) * 256) / d1;
      f2 = ((vn - vc) * 256) / d2;
      return ((f2 - f1) * 512) / (d1 + d2);
    endfunction

    function void note_item(mode_t m, cell_op_t op);
      longint vc, acc;
      if (m == MODE_WRITE) begin
        cells[op.idx] = op.val;
        return;
      end
      vc = longint'(cells[op.idx]);
      acc = axis(spacing[REG_DIST_MX], spacing[REG_DIST_PX], pick(op.nmx, vc), vc,
                 pick(op.npx, vc));
      acc += axis(spacing[REG_DIST_MY], spacing[REG_DIST_PY], pick(op.nmy, vc), vc,
                  pick(op.npy, vc));
      acc += axis(spacing[REG_DIST_MZ], spacing[REG_DIST_PZ], pick(op.nmz, vc), vc,
                  pick(op.npz, vc));
      if (acc > 64'sd140737488355327) acc = 64'sd140737488355327;
      if (acc < -64'sd140737488355328) acc = -64'sd140737488355328;
      pending.push_back(acc[LAP_W-1:0]);
    endfunction

    function void check_result(logic [LAP_W-1:0] got);
      logic signed [LAP_W-1:0] want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected laplacian result %0d", $time, $signed(got));
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got !== want) begin
        $display("%0t: laplacian mismatch, expected %0d actual %0d", $time, want,
                 $signed(got));
        errors++;
      end
    endfunction
  endclass

  laplacian_scoreboard board;
  int  in_idle_pct, out_idle_pct;
  int  accepted_cycles;
  bit  out_hold;
  int  n_items;

  grid_laplacian_nonuniform dut (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // watchdog: cycles without any transaction
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) accepted_cycles <= 0;
    else accepted_cycles <= accepted_cycles + 1;
    if (accepted_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata);
    if (rst_n && in_tvalid && in_tready) board.note_item(mode_t'(in_tuser), in_tdata);
  end

  // receiver
  always @(negedge clk) begin
    if (!rst_n) out_tready <= 0;
    else out_tready <= !out_hold && ($urandom_range(99) >= out_idle_pct);
  end

  task automatic write_reg(cfg_reg_t r, logic [DIST_W-1:0] v);
    @(negedge clk);
    cfg_we <= 1;
    cfg_idx <= r;
    cfg_wdata <= v;
    board.spacing[r] = v;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // valid stays high on return; the next send either reloads it or takes it down, as does drain
  task automatic send(mode_t m, cell_op_t op);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 0;
      @(negedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= m;
    in_tdata <= op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    n_items++;
  endtask

  function automatic logic signed [NB_W-1:0] rand_nb(int span);
    int r;
    r = $urandom_range(9);
    if (r == 0) return {1'b1, 15'($urandom)};
    if (r == 1) return NB_W'(-$urandom_range(1, 32768));
    if (r == 2) return NB_W'(GRID_CELLS + $urandom_range(28000));
    return NB_W'($urandom_range(span - 1));
  endfunction

  task automatic store(int idx, logic signed [VAL_W-1:0] v);
    cell_op_t op;
    op = '0;
    op.idx = IDX_W'(idx);
    op.val = v;
    op.npx = NB_W'($urandom);
    op.nmz = NB_W'($urandom);
    send(MODE_WRITE, op);
  endtask

  // compute at centre c; neighbours within written span only when in grid
  task automatic probe(int c, int span);
    cell_op_t op;
    op = '0;
    op.idx = IDX_W'(c);
    op.val = VAL_W'($urandom);
    op.npx = rand_nb(span); op.nmx = rand_nb(span);
    op.npy = rand_nb(span); op.nmy = rand_nb(span);
    op.npz = rand_nb(span); op.nmz = rand_nb(span);
    send(MODE_COMPUTE, op);
  endtask

  task automatic set_dists(int kind);
    for (int r = 0; r < 6; r++) begin
      case (kind)
        0: write_reg(cfg_reg_t'(r), 16'd1);
        1: write_reg(cfg_reg_t'(r), 16'hFFFF);
        2: write_reg(cfg_reg_t'(r), 16'd0);
        default: write_reg(cfg_reg_t'(r), DIST_W'($urandom_range(1, 2048)));
      endcase
    end
  endtask

  initial begin
    cell_op_t op;
    int span;
    board = new();
    board.clear();
    rst_n = 0;
    in_tvalid = 0; in_tdata = '0; in_tuser = 0;
    cfg_we = 0; cfg_idx = '0; cfg_wdata = '0;
    out_hold = 0; n_items = 0; accepted_cycles = 0;
    in_idle_pct = 11; out_idle_pct = 11;
    repeat (5) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: extreme values, boundaries, out-of-grid neighbours
    store(0, 32'sh7FFF_FFFF);
    store(1, 32'sh8000_0000);
    store(2, 0);
    store(GRID_CELLS - 1, 32'sh8000_0000);
    for (int k = 3; k < 16; k++) store(k, $urandom);
    op = '0; op.idx = 0;
    op.npx = 1; op.nmx = 1; op.npy = NB_W'(GRID_CELLS - 1); op.nmy = -1;
    op.npz = 16'sh7FFF; op.nmz = 16'sh8000;
    send(MODE_COMPUTE, op);
    op.idx = 1; op.npx = 0; op.nmx = 0; op.npy = 0; op.nmy = 0; op.npz = 0;
    op.nmz = NB_W'(GRID_CELLS);
    send(MODE_COMPUTE, op);
    drain();
    set_dists(0);
    op.idx = 1; op.npx = 0; op.nmx = NB_W'(GRID_CELLS - 1); op.npy = 0; op.nmy = 0;
    op.npz = 0; op.nmz = 0;
    send(MODE_COMPUTE, op);
    op.idx = 0; op.npx = 1; op.nmx = 1; op.npy = 1; op.nmy = 1; op.npz = 1;
    op.nmz = 1;
    send(MODE_COMPUTE, op);
    drain();
    set_dists(1);
    send(MODE_COMPUTE, op);
    drain();
    set_dists(2);
    send(MODE_COMPUTE, op);
    // writes beyond the grid cannot occur with a 12-bit index of 4096 cells
    op.idx = 12'hFFF; send(MODE_COMPUTE, op);
    drain();

    // random phases; writes fill a window first so reads stay on written cells
    span = 16;
    for (int phase = 0; phase < 6; phase++) begin
      set_dists(phase == 5 ? 1 : 3);
      in_idle_pct = (phase == 2) ? 0 : 11;
      out_idle_pct = (phase == 2) ? 0 : 11;
      for (int k = 0; k < 200; k++) begin
        if ($urandom_range(99) < 60 || span < GRID_CELLS) begin
          if (span < GRID_CELLS && $urandom_range(2) == 0) begin
            store(span, $urandom);
            span++;
          end else if ($urandom_range(1)) begin
            store($urandom_range(span - 1), $urandom);
          end else begin
            probe($urandom_range(span - 1), span);
          end
        end else begin
          probe($urandom_range(span - 1), span);
        end
        if (phase == 3 && k == 20) begin
          fork
            begin
              out_hold = 1;
              repeat (3000) @(negedge clk);
              out_hold = 0;
            end
          join_none
        end
      end
      // pause until every expected result is back
      drain();
    end

    $display("covered %0d items, %0d laplacian results checked, distances 0/1/max/random",
             n_items, board.checked);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
